// File: hdl/spc_pkg.sv
// Shared types and constants for the sieve prime counter.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int LIMIT_W = 17;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    // Largest limit the input port can carry.
    localparam int PORT_LIMIT = (1 << LIMIT_W) - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_OUTER,
        ST_TEST,
        ST_MARK,
        ST_COUNT,
        ST_DRAIN
    } state_t;

endpackage

// File: hdl/spc_bitmap.sv
// Composite-mark bitmap: one write port, one registered read port.
`timescale 1ns / 1ps

module spc_bitmap #(
    parameter int DEPTH = 65537,
    parameter int AW    = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sieve_prime_counter.sv
// Sequence: a limit above MAX_LIMIT gives done (with out_of_range) straight from idle;
// otherwise clear entries 0..n, walk outer/test over i while i*i <= n, mark the multiples
// of each prime p found (from 2p up to n), count unmarked entries 2..n, then drain and raise done.
// Throughput: one word at a time; busy stays high until the bitmap walk ends,
// set by the walk making one bitmap access per cycle (a write or a registered read).
// Reset (rst_n low, async) returns control to idle; bitmap contents need no reset.
`timescale 1ns / 1ps

module sieve_prime_counter #(
    parameter int MAX_LIMIT = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spc_pkg::LIMIT_W-1:0]   limit,
    output logic                          done,
    output logic [spc_pkg::COUNT_W-1:0]   prime_count,
    output logic                          out_of_range
);

    localparam int MEM_LIMIT = (MAX_LIMIT < spc_pkg::PORT_LIMIT) ? MAX_LIMIT
                                                                 : spc_pkg::PORT_LIMIT;
    localparam int DEPTH = MEM_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (AW + 1) / 2 + 1;
    localparam int SW    = 2 * IW;

    spc_pkg::state_t state_reg, state_next;

    logic [AW-1:0]  n_reg, n_next;
    logic [AW:0]    k_reg, k_next;
    logic [AW:0]    j_reg, j_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [SW-1:0]  sq_reg, sq_next;
    logic           pend_reg, pend_next;
    logic [spc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic           done_reg, done_next;
    logic           oor_reg, oor_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic           mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic           mem_rdata;

    spc_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        i_reg     <= i_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
        oor_reg   <= oor_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        pend_next  = 1'b0;
        count_next = count_reg;
        done_next  = 1'b0;
        oor_next   = oor_reg;
        mem_we     = 1'b0;
        mem_waddr  = k_reg[AW-1:0];
        mem_wdata  = 1'b0;
        mem_raddr  = k_reg[AW-1:0];

        case (state_reg)
            spc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (32'(limit) > 32'(MAX_LIMIT))
                    begin
                        count_next = '0;
                        oor_next   = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        n_next     = AW'(limit);
                        k_next     = '0;
                        count_next = '0;
                        oor_next   = 1'b0;
                        state_next = spc_pkg::ST_CLEAR;
                    end
                end
            end

            spc_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg[AW-1:0];
                mem_wdata = 1'b0;
                k_next    = k_reg + 1'b1;
                if (k_reg[AW-1:0] == n_reg)
                begin
                    i_next     = IW'(2);
                    sq_next    = SW'(4);
                    state_next = spc_pkg::ST_OUTER;
                end
            end

            spc_pkg::ST_OUTER:
            begin
                mem_raddr = AW'(i_reg);
                if (32'(sq_reg) > 32'(n_reg))
                begin
                    k_next     = (AW+1)'(2);
                    state_next = spc_pkg::ST_COUNT;
                end
                else
                begin
                    state_next = spc_pkg::ST_TEST;
                end
            end

            spc_pkg::ST_TEST:
            begin
                if (!mem_rdata)
                begin
                    j_next     = (AW+1)'(i_reg) << 1;
                    state_next = spc_pkg::ST_MARK;
                end
                else
                begin
                    // (i+1)^2 = i^2 + 2i + 1
                    sq_next    = sq_reg + (SW'(i_reg) << 1) + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = spc_pkg::ST_OUTER;
                end
            end

            spc_pkg::ST_MARK:
            begin
                if (j_reg > (AW+1)'(n_reg))
                begin
                    sq_next    = sq_reg + (SW'(i_reg) << 1) + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = spc_pkg::ST_OUTER;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[AW-1:0];
                    mem_wdata = 1'b1;
                    j_next    = j_reg + (AW+1)'(i_reg);
                end
            end

            spc_pkg::ST_COUNT:
            begin
                // read data lands in the cycle after its address; pend tracks it
                if (pend_reg && !mem_rdata && count_reg != spc_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                mem_raddr = k_reg[AW-1:0];
                if (k_reg <= (AW+1)'(n_reg))
                begin
                    pend_next = 1'b1;
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    state_next = spc_pkg::ST_DRAIN;
                end
            end

            spc_pkg::ST_DRAIN:
            begin
                if (pend_reg && !mem_rdata && count_reg != spc_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = spc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = spc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != spc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign prime_count  = count_reg;
    assign out_of_range = oor_reg;

endmodule
